// ----- src/uapf_pkg.sv -----
// shared types and constants for the playback ring and feedback block
`timescale 1ns / 1ps

package uapf_pkg;

    localparam int CMD_W        = 2;
    localparam int HEAD_W       = 10;
    localparam int BYTES_W      = 9;
    localparam int FRAME_W      = 48;
    localparam int IDX_W        = 9;
    localparam int SAMPLE_W     = 24;
    localparam int FB_W         = 32;

    localparam int BYTES_PER_FRAME = 6;

    localparam logic [FB_W-1:0] FB_RESET = 32'h0030_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACTIVATE   = 2'd0,
        CMD_DEACTIVATE = 2'd1,
        CMD_HEADER     = 2'd2,
        CMD_FRAME      = 2'd3
    } t_cmd;

    typedef struct packed {
        logic                write_valid;
        logic [IDX_W-1:0]    write_index;
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] right_sample;
        logic                packet_accepted;
        logic [FB_W-1:0]     feedback_value;
    } t_result;

endpackage

// ----- src/usb_audio_playback_ring_feedback.sv -----
// top level: usb audio playback ring writer with 16.16 rate feedback
//
//  port group  dir  contents
//  s_axis      in   tuser: command; tdata: head, packet bytes, frame bytes
//  m_axis      out  tuser: write flag, accept flag; tdata: index, samples, feedback
//
// one beat per cycle sustained while m_axis takes every result; an input register
// (holding the reduced head and frame count) and a result register lie around the
// single state update pass between input beat and result beat.
// reset is synchronous on i_rst_n: both stages empty, stream inactive,
// feedback back to 48.0.
// with m_axis stalled the result holds and one more input beat is taken
// into the input register before s_axis_tready drops.
`timescale 1ns / 1ps

module usb_audio_playback_ring_feedback
    import uapf_pkg::*;
#(
    parameter int RING_FRAMES      = 512,
    parameter int MAX_PACKET_BYTES = 294
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // dma_head_words, packet_bytes, frame_bytes, pad
    input  logic [1:0]  s_axis_tuser,   // command

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // write_index, left, right, feedback_value, pad
    output logic [1:0]  m_axis_tuser    // write_valid, packet_accepted
);

    localparam int PW        = $clog2(RING_FRAMES);
    localparam int HRW       = PW + 1;
    localparam int FW        = $clog2(MAX_PACKET_BYTES / BYTES_PER_FRAME + 1);
    localparam int SW        = 10;
    localparam int DIV_SHIFT = 12;
    // floor(b/6) == (b*683) >> 12 for every b below 2048
    localparam logic [SW-1:0] DIV6_MUL = 10'd683;

    logic                  r_in_valid;
    t_cmd                  r_in_cmd;
    logic [HRW-1:0]        r_in_head;
    logic [FW-1:0]         r_in_frames;
    logic [FRAME_W-1:0]    r_in_frame;

    logic                  r_out_valid;
    t_result               r_out;

    logic                  adv;
    logic                  in_beat;
    logic [HRW-1:0]        head_red;
    logic [SW-1:0]         bytes_sat;
    logic [2*SW-1:0]       div_prod;
    logic [FW-1:0]         frames;
    t_result               res;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    uapf_head_mod #(
        .DIVISOR (2 * RING_FRAMES)
    ) u_head_mod (
        .i_val (s_axis_tdata[HEAD_W-1:0]),
        .o_rem (head_red)
    );

    always_comb begin
        bytes_sat = SW'(s_axis_tdata[HEAD_W +: BYTES_W]);
        if (bytes_sat > SW'(MAX_PACKET_BYTES)) begin
            bytes_sat = SW'(MAX_PACKET_BYTES);
        end
        div_prod = (2*SW)'(bytes_sat) * (2*SW)'(DIV6_MUL);
        frames   = FW'(div_prod[2*SW-1:DIV_SHIFT]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cmd    <= CMD_DEACTIVATE;
            r_in_head   <= '0;
            r_in_frames <= '0;
            r_in_frame  <= '0;
        end else if (in_beat) begin
            r_in_cmd    <= t_cmd'(s_axis_tuser);
            r_in_head   <= head_red;
            r_in_frames <= frames;
            r_in_frame  <= s_axis_tdata[HEAD_W+BYTES_W +: FRAME_W];
        end
    end

    uapf_core #(
        .RING_FRAMES      (RING_FRAMES),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_cmd    (r_in_cmd),
        .i_head   (r_in_head),
        .i_frames (r_in_frames),
        .i_frame  (r_in_frame),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.packet_accepted, r_out.write_valid};
    assign m_axis_tdata  = {7'd0, r_out.feedback_value, r_out.right_sample,
                            r_out.left_sample, r_out.write_index};

endmodule

// ----- src/uapf_head_mod.sv -----
// reduces the dma head word position modulo the ring length in words
`timescale 1ns / 1ps

module uapf_head_mod
    import uapf_pkg::*;
#(
    parameter int DIVISOR = 1024
) (
    input  logic [HEAD_W-1:0]           i_val,
    output logic [$clog2(DIVISOR)-1:0]  o_rem
);

    localparam int DW    = $clog2(DIVISOR);
    localparam int NSTEP = (DW > HEAD_W) ? 0 : HEAD_W - DW + 1;
    localparam int CW    = HEAD_W + DW + 1;

    logic [CW-1:0] v;

    // restoring reduction, one shifted divisor per step
    always_comb begin
        v = CW'(i_val);
        for (int k = NSTEP - 1; k >= 0; k--) begin
            if (v >= (CW'(DIVISOR) << k)) begin
                v = v - (CW'(DIVISOR) << k);
            end
        end
        o_rem = DW'(v);
    end

endmodule

// ----- src/uapf_feedback.sv -----
// head delta and 16.16 feedback filter update
`timescale 1ns / 1ps

module uapf_feedback
    import uapf_pkg::*;
#(
    parameter int RING_FRAMES = 512
) (
    input  logic [$clog2(RING_FRAMES):0] i_head,
    input  logic [$clog2(RING_FRAMES):0] i_prev,
    input  logic [FB_W-1:0]              i_fb,
    output logic [FB_W-1:0]              o_fb
);

    localparam int HRW = $clog2(RING_FRAMES) + 1;

    logic [HRW:0]    delta;
    logic [FB_W-1:0] measured;
    logic [FB_W-1:0] sum;

    always_comb begin
        // wrap over two ring lengths of words when the head passed zero
        delta = {1'b0, i_head} - {1'b0, i_prev};
        if (i_head < i_prev) begin
            delta = delta + (HRW+1)'(2 * RING_FRAMES);
        end
        measured = FB_W'(delta[HRW:1]) << 16;
        sum      = i_fb + {i_fb[FB_W-2:0], 1'b0} + measured;
        o_fb     = {2'b00, sum[FB_W-1:2]};
    end

endmodule

// ----- src/uapf_core.sv -----
// stream state registers and per-item ring and feedback logic
`timescale 1ns / 1ps

module uapf_core
    import uapf_pkg::*;
#(
    parameter int RING_FRAMES     = 512,
    parameter int MAX_PACKET_BYTES = 294
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_adv,
    input  t_cmd                                          i_cmd,
    input  logic [$clog2(RING_FRAMES):0]                  i_head,
    input  logic [$clog2(MAX_PACKET_BYTES/BYTES_PER_FRAME+1)-1:0] i_frames,
    input  logic [FRAME_W-1:0]                            i_frame,
    output t_result                                       o_res
);

    localparam int PW     = $clog2(RING_FRAMES);
    localparam int HRW    = PW + 1;
    localparam int FW     = $clog2(MAX_PACKET_BYTES / BYTES_PER_FRAME + 1);
    localparam int EW     = PW + 2;
    localparam int KW     = PW + FW + 2;
    localparam int R_HALF = RING_FRAMES / 2;

    logic            r_active, n_active;
    logic [PW-1:0]   r_wp,     n_wp;
    logic [HRW-1:0]  r_prev,   n_prev;
    logic [FW-1:0]   r_frames, n_frames;
    logic [FB_W-1:0] r_fb,     n_fb;

    logic [PW-1:0]   head_half;
    logic [EW-1:0]   act_sum;
    logic [EW-1:0]   space_raw;
    logic [EW-1:0]   space;
    logic [EW-1:0]   wp_inc;
    logic            fits;
    logic [FB_W-1:0] fb_upd;

    uapf_feedback #(
        .RING_FRAMES (RING_FRAMES)
    ) u_feedback (
        .i_head (i_head),
        .i_prev (r_prev),
        .i_fb   (r_fb),
        .o_fb   (fb_upd)
    );

    always_comb begin
        head_half = i_head[HRW-1:1];

        act_sum = EW'(head_half) + EW'(R_HALF);
        if (act_sum >= EW'(RING_FRAMES)) begin
            act_sum = act_sum - EW'(RING_FRAMES);
        end

        // free slots between write position and read head, one kept empty
        space_raw = EW'(head_half) + EW'(RING_FRAMES) - EW'(r_wp) - EW'(1);
        space     = space_raw;
        if (space_raw >= EW'(RING_FRAMES)) begin
            space = space_raw - EW'(RING_FRAMES);
        end
        fits = KW'(space) >= KW'(i_frames);

        wp_inc = EW'(r_wp) + EW'(1);
        if (wp_inc == EW'(RING_FRAMES)) begin
            wp_inc = '0;
        end
    end

    always_comb begin
        n_active = r_active;
        n_wp     = r_wp;
        n_prev   = r_prev;
        n_frames = r_frames;
        n_fb     = r_fb;

        o_res                 = '0;

        unique case (i_cmd)
            CMD_ACTIVATE: begin
                n_wp     = PW'(act_sum);
                n_prev   = i_head;
                n_active = 1'b1;
                n_frames = '0;
            end
            CMD_DEACTIVATE: begin
                n_active = 1'b0;
                n_frames = '0;
            end
            CMD_HEADER: begin
                if (r_active) begin
                    o_res.packet_accepted = fits;
                    n_frames = fits ? i_frames : '0;
                    n_prev   = i_head;
                    n_fb     = fb_upd;
                end
            end
            CMD_FRAME: begin
                if (r_active && (r_frames != '0)) begin
                    o_res.write_valid  = 1'b1;
                    o_res.write_index  = IDX_W'(r_wp);
                    o_res.left_sample  = i_frame[SAMPLE_W-1:0];
                    o_res.right_sample = i_frame[2*SAMPLE_W-1:SAMPLE_W];
                    n_wp     = PW'(wp_inc);
                    n_frames = r_frames - FW'(1);
                end
            end
        endcase

        o_res.feedback_value = n_fb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_wp     <= '0;
            r_prev   <= '0;
            r_frames <= '0;
            r_fb     <= FB_RESET;
        end else if (i_adv) begin
            r_active <= n_active;
            r_wp     <= n_wp;
            r_prev   <= n_prev;
            r_frames <= n_frames;
            r_fb     <= n_fb;
        end
    end

    a_frames_need_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frames != '0) |-> r_active)
        else $error("frames pending on an inactive stream");

    a_wp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wp} < (PW+1)'(RING_FRAMES)))
        else $error("write position outside the ring");

    a_prev_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_prev} < (HRW+1)'(2 * RING_FRAMES)))
        else $error("recorded head outside the ring");

    a_fb_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fb[FB_W-1:FB_W-2] == 2'b00))
        else $error("feedback filter top bits set after divide by four");

    a_write_xor_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |-> !(o_res.write_valid && o_res.packet_accepted))
        else $error("one beat both writes a frame and accepts a packet");

endmodule

// ----- tb/playback_ring_checker.sv -----
// stream checker: predicts each result beat of the playback ring block and compares it
`timescale 1ns / 1ps

module playback_ring_checker
    import uapf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,   // dma_head_words, packet_bytes, frame_bytes, pad
    input  logic [1:0]  i_s_tuser,   // command
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,   // write_index, left, right, feedback_value, pad
    input  logic [1:0]  i_m_tuser,   // write_valid, packet_accepted
    output int          o_fail_count,
    output int          o_pending
);

    localparam int RING_FRAMES      = 512;
    localparam int MAX_PACKET_BYTES = 294;

    t_result expected_results[$];

    logic                stream_on;
    logic [IDX_W-1:0]    wr_slot;
    logic [HEAD_W-1:0]   last_head;
    logic [5:0]          frames_left;
    logic [FB_W-1:0]     rate_fb;

    int fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input logic [47:0] want,
                                   input logic [47:0] got);
        $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
        fail_count++;
    endtask

    // one beat through the ring writer and feedback filter
    task automatic predict_ring_write(input t_cmd cmd, input logic [HEAD_W-1:0] head,
                                      input logic [BYTES_W-1:0] nbytes,
                                      input logic [FRAME_W-1:0] frame,
                                      output t_result res);
        logic [BYTES_W-1:0] sat_bytes;
        logic [5:0]         nframes;
        logic [IDX_W-1:0]   space;
        logic [HEAD_W-1:0]  delta;
        logic [FB_W-1:0]    measured;
        res = '0;
        case (cmd)
            CMD_ACTIVATE: begin
                // half a ring ahead of the read head, in frames
                wr_slot     = head[HEAD_W-1:1] + IDX_W'(RING_FRAMES / 2);
                last_head   = head;
                stream_on   = 1'b1;
                frames_left = '0;
            end
            CMD_DEACTIVATE: begin
                stream_on   = 1'b0;
                frames_left = '0;
            end
            CMD_HEADER: begin
                if (stream_on) begin
                    sat_bytes = (nbytes > MAX_PACKET_BYTES) ?
                                BYTES_W'(MAX_PACKET_BYTES) : nbytes;
                    nframes = 6'(sat_bytes / BYTES_PER_FRAME);
                    space   = head[HEAD_W-1:1] - wr_slot - 1'b1;
                    if (space >= nframes) begin
                        res.packet_accepted = 1'b1;
                        frames_left         = nframes;
                    end else begin
                        frames_left = '0;
                    end
                    // head delta wraps over the 2*ring word range
                    delta     = head - last_head;
                    last_head = head;
                    measured  = FB_W'(delta >> 1) << 16;
                    rate_fb   = (rate_fb * 32'd3 + measured) >> 2;
                end
            end
            default: begin
                if (stream_on && frames_left != 0) begin
                    res.write_valid  = 1'b1;
                    res.write_index  = wr_slot;
                    res.left_sample  = frame[23:0];
                    res.right_sample = frame[47:24];
                    wr_slot          = wr_slot + 1'b1;
                    frames_left      = frames_left - 1'b1;
                end
            end
        endcase
        res.feedback_value = rate_fb;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result predicted;
        if (!i_rst_n) begin
            stream_on   = 1'b0;
            wr_slot     = '0;
            last_head   = '0;
            frames_left = '0;
            rate_fb     = FB_RESET;
            expected_results.delete();
        end else begin
            // retire before predicting: an older beat may leave on the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.write_valid     = i_m_tuser[0];
                got.packet_accepted = i_m_tuser[1];
                got.write_index     = i_m_tdata[8:0];
                got.left_sample     = i_m_tdata[32:9];
                got.right_sample    = i_m_tdata[56:33];
                got.feedback_value  = i_m_tdata[88:57];
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", '0, i_m_tdata[47:0]);
                end else begin
                    want = expected_results.pop_front();
                    if (got.write_valid !== want.write_valid)
                        report_mismatch("write_valid", want.write_valid, got.write_valid);
                    if (got.write_index !== want.write_index)
                        report_mismatch("write_index", want.write_index, got.write_index);
                    if (got.left_sample !== want.left_sample)
                        report_mismatch("left_sample", want.left_sample, got.left_sample);
                    if (got.right_sample !== want.right_sample)
                        report_mismatch("right_sample", want.right_sample, got.right_sample);
                    if (got.packet_accepted !== want.packet_accepted)
                        report_mismatch("packet_accepted", want.packet_accepted,
                                        got.packet_accepted);
                    if (got.feedback_value !== want.feedback_value)
                        report_mismatch("feedback_value", want.feedback_value,
                                        got.feedback_value);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_ring_write(t_cmd'(i_s_tuser), i_s_tdata[9:0], i_s_tdata[18:10],
                                   i_s_tdata[66:19], predicted);
                expected_results.push_back(predicted);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// testbench top: drives activate, deactivate, header and frame beats into the block
`timescale 1ns / 1ps

module tb_top
    import uapf_pkg::*;
();

    localparam int CYCLE_LIMIT = 100000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // dma_head_words, packet_bytes, frame_bytes, pad
    logic [1:0]  s_axis_tuser = '0;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // write_index, left, right, feedback_value, pad
    logic [1:0]  m_axis_tuser;        // write_valid, packet_accepted

    int fail_count;
    int pending;
    int beats_sent = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_count = 0;
    logic rx_hold_req = 1'b0;

    // sender-side view of the stream, only used to shape realistic packets
    logic [HEAD_W-1:0] stream_head = '0;
    logic              tb_active = 1'b0;

    usb_audio_playback_ring_feedback u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    playback_ring_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("usb_audio_playback_ring_feedback test failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (rx_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 64;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [FRAME_W-1:0] rand_frame();
        return FRAME_W'({$urandom, $urandom});
    endfunction

    task automatic send_beat(input t_cmd cmd, input logic [HEAD_W-1:0] head,
                             input logic [BYTES_W-1:0] nbytes,
                             input logic [FRAME_W-1:0] frame);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'b0, frame, nbytes, head};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    // header, head moved about as far as its frames or at random, then mostly its frames
    task automatic send_packet();
        logic [BYTES_W-1:0] nbytes;
        int nframes;
        int nsend;
        if ($urandom_range(99) < 85)
            nbytes = BYTES_W'($urandom_range(0, 120));
        else
            nbytes = BYTES_W'($urandom_range(0, 511));
        nframes = ((nbytes > 294) ? 294 : nbytes) / BYTES_PER_FRAME;
        if ($urandom_range(99) < 5)
            stream_head = HEAD_W'($urandom);
        else
            stream_head = stream_head + HEAD_W'(2 * nframes) + HEAD_W'($urandom_range(0, 6))
                          - HEAD_W'(3);
        send_beat(CMD_HEADER, stream_head, nbytes, rand_frame());
        case ($urandom_range(9))
            0:       nsend = nframes + $urandom_range(1, 3);
            1:       nsend = (nframes > 0) ? $urandom_range(0, nframes - 1) : 0;
            default: nsend = nframes;
        endcase
        repeat (nsend) send_beat(CMD_FRAME, HEAD_W'($urandom), BYTES_W'($urandom),
                                 rand_frame());
    endtask

    task automatic run_random(input int upto);
        int pick;
        t_cmd cmd;
        while (beats_sent < upto) begin
            pick = $urandom_range(99);
            if ((!tb_active && pick < 60) || pick < 3) begin
                stream_head = HEAD_W'($urandom);
                send_beat(CMD_ACTIVATE, stream_head, BYTES_W'($urandom), rand_frame());
                tb_active = 1'b1;
            end else if (pick < 6) begin
                send_beat(CMD_DEACTIVATE, HEAD_W'($urandom), BYTES_W'($urandom),
                          rand_frame());
                tb_active = 1'b0;
            end else if (pick < 14) begin
                // noise beat of any kind with arbitrary fields
                cmd = t_cmd'($urandom_range(3));
                send_beat(cmd, HEAD_W'($urandom), BYTES_W'($urandom), rand_frame());
                if (cmd == CMD_ACTIVATE)
                    tb_active = 1'b1;
                else if (cmd == CMD_DEACTIVATE)
                    tb_active = 1'b0;
            end else begin
                send_packet();
            end
        end
    endtask

    initial begin
        int base;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stream not yet active: header and frame do nothing
        send_beat(CMD_HEADER, 10'd1023, 9'd294, 48'hFFFF_FFFF_FFFF);
        send_beat(CMD_FRAME, 10'd1023, 9'd511, 48'hFFFF_FFFF_FFFF);
        send_beat(CMD_ACTIVATE, 10'd1023, 9'd511, '0);
        // empty packet, head unchanged
        send_beat(CMD_HEADER, 10'd1023, 9'd0, '0);
        // oversized packet saturates, head wraps past the top
        send_beat(CMD_HEADER, 10'd5, 9'd511, 48'hFFFF_FFFF_FFFF);
        send_beat(CMD_FRAME, 10'd0, 9'd0, 48'h0000_0000_0000);
        send_beat(CMD_FRAME, 10'd1023, 9'd511, 48'hFFFF_FFFF_FFFF);
        send_beat(CMD_FRAME, 10'd341, 9'd170, 48'h5A5A_A5A5_3C3C);
        // new header replaces the pending count
        send_beat(CMD_HEADER, 10'd100, 9'd295, 48'hA5A5_5A5A_C3C3);
        send_beat(CMD_FRAME, 10'd682, 9'd341, 48'h1234_5678_9ABC);
        send_beat(CMD_DEACTIVATE, 10'd1023, 9'd511, 48'hFFFF_FFFF_FFFF);
        send_beat(CMD_FRAME, 10'd0, 9'd0, 48'hFEDC_BA98_7654);
        send_beat(CMD_ACTIVATE, 10'd0, 9'd0, '0);
        // ring full: no free space, packet dropped
        send_beat(CMD_HEADER, 10'd514, 9'd12, '0);
        send_beat(CMD_FRAME, 10'd0, 9'd0, 48'h0F0F_0F0F_0F0F);
        send_beat(CMD_HEADER, 10'd600, 9'd6, '0);
        send_beat(CMD_FRAME, 10'd0, 9'd0, 48'hF0F0_F0F0_F0F0);
        // surplus frame after the packet is done
        send_beat(CMD_FRAME, 10'd0, 9'd0, 48'h8000_0180_0001);
        send_beat(CMD_HEADER, 10'd600, 9'd5, '0);
        send_beat(CMD_ACTIVATE, 10'd1022, 9'd0, '0);
        send_beat(CMD_HEADER, 10'd10, 9'd288, '0);
        send_beat(CMD_FRAME, 10'd0, 9'd0, 48'h7FFF_FF80_0000);
        tb_active   = 1'b1;
        stream_head = 10'd10;

        base = beats_sent;
        tx_idle_pct = 31;
        rx_idle_pct = 51;
        run_random(base + 180);
        tx_idle_pct = 51;
        rx_idle_pct = 31;
        run_random(base + 360);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        run_random(base + 550);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("usb_audio_playback_ring_feedback test passed");
        end else begin
            $display("usb_audio_playback_ring_feedback test failed");
        end
        $finish;
    end

endmodule
